// ----- sv/ofcs_pkg.sv -----
package ofcs_pkg;

	// fixed field widths
	localparam int HeightW  = 11;
	localparam int WidthW   = 16;
	localparam int AbsW     = 13;
	localparam int RelW     = 14;
	localparam int ScoreW   = 17;
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 16;

	// register reset values
	localparam logic [HeightW-1:0] HeightRst = 11'd1024;
	localparam logic [WidthW-1:0]  WidthRst  = 16'd1024;
	localparam logic [AbsW-1:0]    AbsRst    = 13'd0;
	localparam logic [RelW-1:0]    RelRst    = 14'd3;

	// register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_HEIGHT = 8'd0,
		REG_WIDTH  = 8'd1,
		REG_ABS    = 8'd2,
		REG_REL    = 8'd3
	} ofcs_reg_t;

	// control travelling alongside each word in the score pipeline
	typedef struct packed {
		logic valid;
		logic last;
		logic zero;
	} ofcs_meta_t;

endpackage

// ----- sv/ofcs_if.sv -----
interface ofcs_pix_if #(
	parameter int OffsetBits = 13
);
	logic                         valid;
	logic                         ready;
	logic signed [OffsetBits-1:0] x_offset;
	logic signed [OffsetBits-1:0] y_offset;
	logic                         shielded;

	modport source(output valid, x_offset, y_offset, shielded, input ready);
	modport sink(input valid, x_offset, y_offset, shielded, output ready);
endinterface

interface ofcs_res_if;
	logic                          valid;
	logic                          ready;
	logic [ofcs_pkg::ScoreW-1:0]   score;
	logic                          last_of_map;

	modport source(output valid, score, last_of_map, input ready);
	modport sink(input valid, score, last_of_map, output ready);
endinterface

interface ofcs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [ofcs_pkg::CfgIdxW-1:0]  index;
	logic [ofcs_pkg::CfgDataW-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/ofcs_win_col.sv -----
module ofcs_win_col #(
	parameter int Span = 7,
	parameter int PixW = 27
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic [PixW-1:0]           pix_i,
	output logic [Span-1:0][PixW-1:0] pix_o
);

	logic [Span-1:0][PixW-1:0] col_q;

	// column of window pixels moving up one row per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			for (int a = 0; a < Span - 1; a++) begin
				col_q[a] <= col_q[a+1];
			end
			col_q[Span-1] <= pix_i;
		end
	end

	assign pix_o = col_q;

endmodule

// ----- sv/ofcs_div_cell.sv -----
module ofcs_div_cell #(
	parameter int CntW = 6,
	parameter int QuoW = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ofcs_pkg::ofcs_meta_t meta_i,
	input  logic [CntW-1:0]      rem_i,
	input  logic [CntW-1:0]      dvs_i,
	input  logic                 bit_i,
	input  logic [QuoW-1:0]      quo_i,
	output ofcs_pkg::ofcs_meta_t meta_o,
	output logic [CntW-1:0]      rem_o,
	output logic [CntW-1:0]      dvs_o,
	output logic [QuoW-1:0]      quo_o
);

	logic [CntW:0] trial;
	logic [CntW:0] diff;
	logic          ge;

	// one restoring division step
	assign trial = {rem_i, bit_i};
	assign ge    = trial >= {1'b0, dvs_i};
	assign diff  = trial - {1'b0, dvs_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_o <= '0;
		end else if (en) begin
			meta_o <= meta_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[CntW-1:0] : trial[CntW-1:0];
			dvs_o <= dvs_i;
			quo_o <= {quo_i[QuoW-2:0], ge};
		end
	end

endmodule

// ----- sv/offset_field_consistency_score_top.sv -----
// Offset field consistency score. Pixels of a padded offset map come in column by
// column, each column top to bottom; one score word leaves for every pixel whose
// full (2*RADIUS+1)-square window is in, carrying last_of_map on the map's final
// one. The block takes one pixel per cycle unless the whole pipeline halts, which it
// does while a finished word waits at the output. A word passes the column store read at
// the accepting edge, then the window shift, the compare row, the count sum and a
// chain of 17 divider cells, one quotient bit per cell. The column store has no
// clearing pass; the user must write registers between maps; no check enforces it.
module offset_field_consistency_score_top #(
	parameter int RADIUS         = 3,
	parameter int MAX_COLUMN_LEN = 1024,
	parameter int OFFSET_BITS    = 13
) (
	input  logic   clk,
	input  logic   arst_n,
	ofcs_pix_if.sink   pix_in,
	ofcs_res_if.source res_out,
	ofcs_cfg_if.sink   cfg
);

	localparam int Span      = 2 * RADIUS + 1;
	localparam int StoreCols = 2 * RADIUS;
	localparam int Area      = Span * Span;
	localparam int PixW      = 2 * OFFSET_BITS + 1;
	localparam int AddrW     = $clog2(MAX_COLUMN_LEN);
	localparam int SlotW     = $clog2(StoreCols);
	localparam int CntW      = $clog2(Area + 1);
	localparam int RowW      = $clog2(Span + 1);
	localparam int QuoW      = ofcs_pkg::ScoreW;
	localparam int PosW      = ((AddrW > ofcs_pkg::HeightW) ? AddrW : ofcs_pkg::HeightW) + 1;
	localparam int MagW      = OFFSET_BITS + 1;
	localparam int DistW     = (MagW + 1 > ofcs_pkg::RelW) ? MagW + 1 : ofcs_pkg::RelW;
	localparam int ColW      = ofcs_pkg::WidthW;

	function automatic logic [MagW-1:0] mag(input logic signed [MagW-1:0] v);
		return v[MagW-1] ? MagW'(-v) : MagW'(v);
	endfunction

	// configuration registers
	logic [ofcs_pkg::HeightW-1:0] height_q;
	logic [ofcs_pkg::WidthW-1:0]  width_q;
	logic [ofcs_pkg::AbsW-1:0]    abs_q;
	logic [ofcs_pkg::RelW-1:0]    rel_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= ofcs_pkg::HeightRst;
			width_q  <= ofcs_pkg::WidthRst;
			abs_q    <= ofcs_pkg::AbsRst;
			rel_q    <= ofcs_pkg::RelRst;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ofcs_pkg::REG_HEIGHT: height_q <= cfg.data[ofcs_pkg::HeightW-1:0];
				ofcs_pkg::REG_WIDTH:  width_q  <= cfg.data[ofcs_pkg::WidthW-1:0];
				ofcs_pkg::REG_ABS:    abs_q    <= cfg.data[ofcs_pkg::AbsW-1:0];
				ofcs_pkg::REG_REL:    rel_q    <= cfg.data[ofcs_pkg::RelW-1:0];
				default: ;
			endcase
		end
	end

	// handshake and pipeline advance
	logic en;
	logic acc;
	assign en           = !res_out.valid || res_out.ready;
	assign pix_in.ready = en;
	assign acc          = pix_in.valid && en;

	// scan position
	logic [AddrW-1:0] row_q;
	logic [ColW-1:0]  col_q;
	logic [SlotW-1:0] slot_q;
	logic [PosW-1:0]  h_ext, h_clip, row_nxt;
	logic [ColW:0]    col_nxt;
	logic             col_end, map_end, emit;
	logic [PixW-1:0]  cur;

	assign cur     = {pix_in.shielded, pix_in.y_offset, pix_in.x_offset};
	assign h_ext   = PosW'(height_q);
	assign h_clip  = (h_ext > PosW'(MAX_COLUMN_LEN)) ? PosW'(MAX_COLUMN_LEN) : h_ext;
	assign row_nxt = PosW'(row_q) + PosW'(1);
	assign col_nxt = {1'b0, col_q} + (ColW+1)'(1);
	assign col_end = row_nxt >= h_clip;
	assign map_end = col_end && (col_nxt >= {1'b0, width_q});
	assign emit    = (PosW'(row_q) >= PosW'(StoreCols)) && (col_q >= ColW'(StoreCols));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (col_end) begin
				row_q <= '0;
				if (map_end) begin
					col_q  <= '0;
					slot_q <= '0;
				end else begin
					col_q  <= col_nxt[ColW-1:0];
					slot_q <= ({1'b0, slot_q} == (SlotW+1)'(StoreCols - 1)) ?
						'0 : slot_q + SlotW'(1);
				end
			end else begin
				row_q <= row_nxt[AddrW-1:0];
			end
		end
	end

	// column store, one memory per stored column
	logic [PixW-1:0] rd_s1 [StoreCols];

	for (genvar g = 0; g < StoreCols; g++) begin : g_store
		logic [PixW-1:0] mem [MAX_COLUMN_LEN];

		always_ff @(posedge clk) begin
			if (acc && (slot_q == SlotW'(g))) begin
				mem[row_q] <= cur;
			end
			if (acc) begin
				rd_s1[g] <= mem[row_q];
			end
		end
	end

	// stage 1 word
	logic             v_s1, emit_s1, last_s1;
	logic [PixW-1:0]  cur_s1;
	logic [SlotW-1:0] slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1  <= cur;
			slot_s1 <= slot_q;
			emit_s1 <= emit;
			last_s1 <= map_end;
		end
	end

	// bottom row of the window: stored columns oldest first, then the new pixel
	logic [PixW-1:0] col_in [Span];

	always_comb begin
		logic [SlotW:0] idx;
		for (int b = 0; b < StoreCols; b++) begin
			idx = {1'b0, slot_s1} + (SlotW+1)'(b);
			if (idx >= (SlotW+1)'(StoreCols)) begin
				idx = idx - (SlotW+1)'(StoreCols);
			end
			col_in[b] = rd_s1[idx[SlotW-1:0]];
		end
		col_in[Span-1] = cur_s1;
	end

	logic [Span-1:0][PixW-1:0] win [Span];

	for (genvar b = 0; b < Span; b++) begin : g_col
		ofcs_win_col #(
			.Span(Span),
			.PixW(PixW)
		) u_col (
			.clk(clk),
			.arst_n(arst_n),
			.shift(en && v_s1),
			.pix_i(col_in[b]),
			.pix_o(win[b])
		);
	end

	ofcs_pkg::ofcs_meta_t meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
		end else if (en) begin
			meta_s2.valid <= v_s1 && emit_s1;
			meta_s2.last  <= last_s1;
			meta_s2.zero  <= 1'b0;
		end
	end

	// compare every window pixel with the centre, count per row
	logic [PixW-1:0] ctr;
	logic [RowW-1:0] vrow [Span];
	logic [RowW-1:0] arow [Span];

	assign ctr = win[RADIUS][RADIUS];

	always_comb begin
		logic signed [MagW-1:0] cx, cy, px, py;
		logic [DistW-1:0]       norm, gap;
		logic                   ok;
		cx = {ctr[OFFSET_BITS-1], ctr[OFFSET_BITS-1:0]};
		cy = {ctr[2*OFFSET_BITS-1], ctr[2*OFFSET_BITS-1:OFFSET_BITS]};
		for (int a = 0; a < Span; a++) begin
			vrow[a] = '0;
			arow[a] = '0;
			for (int b = 0; b < Span; b++) begin
				px   = {win[b][a][OFFSET_BITS-1], win[b][a][OFFSET_BITS-1:0]};
				py   = {win[b][a][2*OFFSET_BITS-1], win[b][a][2*OFFSET_BITS-1:OFFSET_BITS]};
				norm = DistW'(mag(px)) + DistW'(mag(py));
				gap  = DistW'(mag(px - cx)) + DistW'(mag(py - cy));
				ok   = norm >= DistW'(abs_q);
				vrow[a] = vrow[a] + RowW'(ok);
				arow[a] = arow[a] + RowW'(ok && (gap < DistW'(rel_q)));
			end
		end
	end

	logic [RowW-1:0]      vrow_s3 [Span];
	logic [RowW-1:0]      arow_s3 [Span];
	logic                 csh_s3;
	ofcs_pkg::ofcs_meta_t meta_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else if (en) begin
			meta_s3 <= meta_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vrow_s3 <= vrow;
			arow_s3 <= arow;
			csh_s3  <= ctr[PixW-1];
		end
	end

	// window totals and the cases that force a zero score
	logic [CntW-1:0] vsum, asum;
	logic [CntW+2:0] v5;
	logic            zero;

	always_comb begin
		vsum = '0;
		asum = '0;
		for (int a = 0; a < Span; a++) begin
			vsum = vsum + CntW'(vrow_s3[a]);
			asum = asum + CntW'(arow_s3[a]);
		end
	end

	assign v5   = (CntW+3)'({vsum, 2'b00}) + (CntW+3)'(vsum);
	assign zero = csh_s3 || (v5 <= (CntW+3)'(Area)) || (vsum == '0);

	ofcs_pkg::ofcs_meta_t meta_s4;
	logic [CntW-1:0]      rem_s4, dvs_s4;
	logic                 bit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s4 <= '0;
		end else if (en) begin
			meta_s4.valid <= meta_s3.valid;
			meta_s4.last  <= meta_s3.last;
			meta_s4.zero  <= zero;
		end
	end

	// dividend is agree shifted up by 16; its top part is agree halved
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s4 <= asum >> 1;
			bit_s4 <= asum[0];
			dvs_s4 <= vsum;
		end
	end

	// divider chain, one quotient bit per cell
	ofcs_pkg::ofcs_meta_t meta_c [QuoW+1];
	logic [CntW-1:0]      rem_c  [QuoW+1];
	logic [CntW-1:0]      dvs_c  [QuoW+1];
	logic [QuoW-1:0]      quo_c  [QuoW+1];

	assign meta_c[0] = meta_s4;
	assign rem_c[0]  = rem_s4;
	assign dvs_c[0]  = dvs_s4;
	assign quo_c[0]  = '0;

	for (genvar k = 0; k < QuoW; k++) begin : g_div
		ofcs_div_cell #(
			.CntW(CntW),
			.QuoW(QuoW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.meta_i(meta_c[k]),
			.rem_i(rem_c[k]),
			.dvs_i(dvs_c[k]),
			.bit_i((k == 0) ? bit_s4 : 1'b0),
			.quo_i(quo_c[k]),
			.meta_o(meta_c[k+1]),
			.rem_o(rem_c[k+1]),
			.dvs_o(dvs_c[k+1]),
			.quo_o(quo_c[k+1])
		);
	end

	// result word
	assign res_out.valid       = meta_c[QuoW].valid;
	assign res_out.score       = meta_c[QuoW].zero ? '0 : quo_c[QuoW];
	assign res_out.last_of_map = meta_c[QuoW].last;

`ifndef SYNTHESIS
	a_map_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		acc && map_end |=> (row_q == '0) && (col_q == '0) && (slot_q == '0))
		else $error("scan position not restarted after map end");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (SlotW+1)'(StoreCols))
		else $error("store slot out of range");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		meta_s4.valid && !meta_s4.zero |-> rem_s4 < dvs_s4)
		else $error("divider start remainder not below divisor");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(meta_s4.valid) && $stable(v_s1))
		else $error("pipeline moved while stalled");
`endif

endmodule
